/* hw/rtl/tlpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared codes and entry layout for the two-level page table manager.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  // operation codes
  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_POOL  = 2'd2;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned ALLOC_W    = 9;
  localparam int unsigned ENTRY_W    = 32;

  localparam logic [31:0] FREE_BASE_RESET = 32'h0010_0000;

  // entry layout: bit 0 present, bit 1 read/write, bit 2 user, 31:12 frame
  function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                    input logic user,
                                                    input logic rw);
    make_entry = {frame, 9'b0, user, rw, 1'b1};
  endfunction

endpackage

/* hw/rtl/tlpt_ram.sv */
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/two_level_page_table_manager.sv */
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Walks, fills and edits 32-bit two-level page tables kept in a local word
// store covering the low physical frames; new tables come from a bump pool.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------
//  in      | in_operation, in_linear_address, in_directory_ | in_valid / in_stall
//          | base, in_physical_address, in_user_access,     |
//          | in_writable                                    |
//  out     | out_frame_base, out_entry_present, out_status  | out_valid/out_stall
//  cfg     | cfg_data (free area base)                      | cfg_valid/cfg_ready
//
//  One request is in flight at a time; the store is one word RAM with one
//  write and one read port, so a walk is two dependent reads.
//  Map into an existing table: directory read and check, entry write;
//  unmap/translate: directory and table entry reads and checks. Unused
//  codes and directories outside the store skip the walk; pool or table
//  range errors, or a missing directory entry on unmap/translate, end at
//  the directory check. A new table is cleared (1024 words), then linked.
//  After reset the whole store (STORE_FRAMES*1024 words, 524288 by default)
//  is cleared one word a cycle; in_stall stays high until the sweep ends.
//  A result waiting on out_stall holds the next request in its final step.
// ----------------------------------------------------------------------------
module two_level_page_table_manager
  import tlpt_pkg::*;
#(
  parameter int STORE_FRAMES = 512,
  parameter int POOL_PAGES   = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_linear_address,
  input  logic [31:0] in_directory_base,
  input  logic [31:0] in_physical_address,
  input  logic        in_user_access,
  input  logic        in_writable,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_frame_base,
  output logic        out_entry_present,
  output logic [1:0]  out_status,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = STORE_FRAMES * 1024;
  localparam int FW    = $clog2(STORE_FRAMES);
  localparam int AW    = FW + IDX_W;

  localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(STORE_FRAMES);
  localparam logic [ALLOC_W-1:0] POOL_LIMIT  = ALLOC_W'(POOL_PAGES);
  localparam logic [AW-1:0]      LAST_WORD   = AW'(DEPTH - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX    = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PDE_RD, S_PDE_CHK, S_ZERO,
    S_LINK, S_PTE_WR, S_PTE_RD, S_PTE_CHK, S_FIN
  } state_t;

  state_t state_r;

  logic [31:0]          free_base_r;
  logic [ALLOC_W-1:0]   alloc_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [IDX_W-1:0]     idx_cnt_r;

  logic [1:0]           op_r;
  logic [IDX_W-1:0]     pde_i_r;
  logic [IDX_W-1:0]     pte_i_r;
  logic [FRAME_W-1:0]   dir_frame_r;
  logic [FRAME_W-1:0]   phys_frame_r;
  logic [FRAME_W-1:0]   tbl_frame_r;
  logic                 user_r;
  logic                 rw_r;

  logic [31:0]          res_frame_r;
  logic                 res_present_r;
  logic [1:0]           res_status_r;

  logic                 out_valid_r;
  logic [31:0]          out_frame_r;
  logic                 out_present_r;
  logic [1:0]           out_status_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 in_beat;
  logic [FRAME_W-1:0]   in_dir_frame;
  logic [FRAME_W-1:0]   alloc_frame;
  logic [FRAME_W-1:0]   pde_frame;
  logic                 pde_present;
  logic                 out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_frame_base    = out_frame_r;
  assign out_entry_present = out_present_r;
  assign out_status        = out_status_r;
  assign out_free          = !out_valid_r || !out_stall;

  assign in_dir_frame = in_directory_base[31:OFFSET_W];
  assign alloc_frame  = free_base_r[31:OFFSET_W] + {{(FRAME_W-ALLOC_W){1'b0}}, alloc_r};
  assign pde_frame    = ram_rdata[31:OFFSET_W];
  assign pde_present  = ram_rdata[0];

  // read side: directory entry first, table entry second
  always_comb begin
    if (state_r == S_PTE_RD) begin
      ram_raddr = {tbl_frame_r[FW-1:0], pte_i_r};
    end else begin
      ram_raddr = {dir_frame_r[FW-1:0], pde_i_r};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {tbl_frame_r[FW-1:0], idx_cnt_r};
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = {dir_frame_r[FW-1:0], pde_i_r};
        ram_wdata = make_entry(tbl_frame_r, user_r, rw_r);
      end
      S_PTE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {tbl_frame_r[FW-1:0], pte_i_r};
        ram_wdata = make_entry(phys_frame_r, user_r, rw_r);
      end
      S_PTE_CHK: begin
        // unmap drops a present entry
        ram_we    = (op_r == OP_UNMAP) && ram_rdata[0];
        ram_waddr = {tbl_frame_r[FW-1:0], pte_i_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      free_base_r <= FREE_BASE_RESET;
      alloc_r     <= '0;
      clr_cnt_r   <= '0;
      idx_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        free_base_r <= cfg_data;
      end
      // the final step reloads the beat itself
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == LAST_WORD) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_beat) begin
            op_r          <= in_operation;
            pde_i_r       <= in_linear_address[31:22];
            pte_i_r       <= in_linear_address[21:12];
            dir_frame_r   <= in_dir_frame;
            phys_frame_r  <= in_physical_address[31:OFFSET_W];
            user_r        <= in_user_access;
            rw_r          <= in_writable;
            res_frame_r   <= '0;
            res_present_r <= 1'b0;
            if (!(in_operation inside {OP_MAP, OP_UNMAP, OP_TRANSLATE})) begin
              res_status_r <= ST_DONE;
              state_r      <= S_FIN;
            end else if (in_dir_frame >= FRAME_LIMIT) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_FIN;
            end else begin
              res_status_r <= ST_DONE;
              state_r      <= S_PDE_RD;
            end
          end
        end

        S_PDE_RD: begin
          state_r <= S_PDE_CHK;
        end

        S_PDE_CHK: begin
          if (op_r == OP_MAP) begin
            if (!pde_present) begin
              if (alloc_r >= POOL_LIMIT) begin
                res_status_r <= ST_POOL;
                state_r      <= S_FIN;
              end else if (alloc_frame >= FRAME_LIMIT) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_FIN;
              end else begin
                tbl_frame_r <= alloc_frame;
                alloc_r     <= alloc_r + ALLOC_W'(1);
                idx_cnt_r   <= '0;
                state_r     <= S_ZERO;
              end
            end else if (pde_frame >= FRAME_LIMIT) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_FIN;
            end else begin
              tbl_frame_r <= pde_frame;
              state_r     <= S_PTE_WR;
            end
          end else if (!pde_present) begin
            state_r <= S_FIN;
          end else if (pde_frame >= FRAME_LIMIT) begin
            res_status_r <= ST_RANGE;
            state_r      <= S_FIN;
          end else begin
            tbl_frame_r <= pde_frame;
            state_r     <= S_PTE_RD;
          end
        end

        S_ZERO: begin
          idx_cnt_r <= idx_cnt_r + IDX_W'(1);
          if (idx_cnt_r == LAST_IDX) begin
            state_r <= S_LINK;
          end
        end

        S_LINK: begin
          state_r <= S_PTE_WR;
        end

        S_PTE_WR: begin
          res_present_r <= 1'b1;
          state_r       <= S_FIN;
        end

        S_PTE_RD: begin
          state_r <= S_PTE_CHK;
        end

        S_PTE_CHK: begin
          res_present_r <= ram_rdata[0];
          if (op_r == OP_TRANSLATE) begin
            res_frame_r <= {ram_rdata[31:OFFSET_W], {OFFSET_W{1'b0}}};
          end
          state_r <= S_FIN;
        end

        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_frame_r   <= res_frame_r;
            out_present_r <= res_present_r;
            out_status_r  <= res_status_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // the bump allocator never runs past the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_r <= POOL_LIMIT)
    else $error("allocation count beyond pool size");

  // the allocator moves only when a missing directory entry is resolved
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(alloc_r) |-> $past(state_r) == S_PDE_CHK)
    else $error("allocation count changed outside a table allocation");

  // an error result carries no frame and no present bit
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (!out_entry_present && out_frame_base == '0))
    else $error("error result with payload");

  // a new result beat is only loaded from the final step
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_FIN)
    else $error("result beat raised outside the final step");

endmodule

/* verif/tb_two_level_page_table_manager.sv */
// ----------------------------------------------------------------------------
// tb_two_level_page_table_manager
// Self-checking bench for the page table manager: directed map, unmap and
// translate walks, range and pool errors, allocator wrap, then random walk
// sequences under three idle/stall mixes, ending with pool exhaustion.
// Every accepted beat is scored against an in-bench model of the tables.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_manager;
  import tlpt_pkg::*;

  localparam int STORE_FRAMES    = 512;
  localparam int POOL_PAGES      = 256;
  localparam int WORDS_PER_FRAME = 1024;
  localparam int IDLE_LIMIT      = 2_000_000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_ITEMS    = 280;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] lin;
    logic [31:0] dir;
    logic [31:0] phys;
    logic        user;
    logic        rw;
  } walk_request_t;

  typedef struct {
    logic [31:0] frame_base;
    logic        present;
    logic [1:0]  status;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_linear_address;
  logic [31:0] in_directory_base;
  logic [31:0] in_physical_address;
  logic        in_user_access;
  logic        in_writable;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_frame_base;
  logic        out_entry_present;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // model of the tables
  logic [31:0]   page_words [int unsigned];
  logic [8:0]    tables_taken;
  logic [31:0]   table_pool_base;
  walk_result_t  due_results[$];
  walk_result_t  oldest_due;

  walk_request_t recent_maps[$];
  logic [19:0]   dir_choices [4];
  logic [9:0]    pde_choices [4];

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count = 0;
  int idle_cycles = 0;

  two_level_page_table_manager #(
    .STORE_FRAMES(STORE_FRAMES),
    .POOL_PAGES  (POOL_PAGES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_linear_address  (in_linear_address),
    .in_directory_base  (in_directory_base),
    .in_physical_address(in_physical_address),
    .in_user_access     (in_user_access),
    .in_writable        (in_writable),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_base     (out_frame_base),
    .out_entry_present  (out_entry_present),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned word_addr(input int unsigned frame, input int unsigned idx);
    return frame * WORDS_PER_FRAME + idx;
  endfunction

  function automatic logic [31:0] read_word(input int unsigned addr);
    if (page_words.exists(addr)) begin
      return page_words[addr];
    end
    return '0;
  endfunction

  // walk the modeled tables for one request and apply its side effects
  function automatic walk_result_t walk_tables(input walk_request_t rq);
    walk_result_t res;
    logic [19:0]  table_frame;
    logic [31:0]  table_addr;
    logic [31:0]  pde;
    logic [31:0]  pte;
    int unsigned  pde_slot;
    int unsigned  pte_slot;
    res.frame_base = '0;
    res.present    = 1'b0;
    res.status     = ST_DONE;
    if (rq.op == OP_UNUSED) begin
      return res;
    end
    if (rq.dir[31:12] >= STORE_FRAMES) begin
      res.status = ST_RANGE;
      return res;
    end
    pde_slot = word_addr(rq.dir[31:12], rq.lin[31:22]);
    pde      = read_word(pde_slot);
    if (rq.op == OP_MAP) begin
      if (!pde[0]) begin
        if (tables_taken >= POOL_PAGES) begin
          res.status = ST_POOL;
          return res;
        end
        // bump pointer wraps at 4 GiB
        table_addr  = {table_pool_base[31:12], 12'h000} + {11'b0, tables_taken, 12'h000};
        table_frame = table_addr[31:12];
        if (table_frame >= STORE_FRAMES) begin
          res.status = ST_RANGE;
          return res;
        end
        for (int i = 0; i < WORDS_PER_FRAME; i++) begin
          page_words.delete(word_addr(table_frame, i));
        end
        tables_taken = tables_taken + 1'b1;
        page_words[pde_slot] = {table_frame, 9'b0, rq.user, rq.rw, 1'b1};
      end else begin
        table_frame = pde[31:12];
        if (table_frame >= STORE_FRAMES) begin
          res.status = ST_RANGE;
          return res;
        end
      end
      page_words[word_addr(table_frame, rq.lin[21:12])] =
        {rq.phys[31:12], 9'b0, rq.user, rq.rw, 1'b1};
      res.present = 1'b1;
      return res;
    end
    if (!pde[0]) begin
      return res;
    end
    table_frame = pde[31:12];
    if (table_frame >= STORE_FRAMES) begin
      res.status = ST_RANGE;
      return res;
    end
    pte_slot = word_addr(table_frame, rq.lin[21:12]);
    pte      = read_word(pte_slot);
    if (rq.op == OP_UNMAP) begin
      if (pte[0]) begin
        page_words.delete(pte_slot);
        res.present = 1'b1;
      end
    end else begin
      res.frame_base = {pte[31:12], 12'h000};
      res.present    = pte[0];
    end
    return res;
  endfunction

  function automatic walk_request_t make_request(input logic [1:0] op, input logic [31:0] lin,
                                                 input logic [31:0] dir, input logic [31:0] phys,
                                                 input logic user, input logic rw);
    walk_request_t rq;
    rq.op   = op;
    rq.lin  = lin;
    rq.dir  = dir;
    rq.phys = phys;
    rq.user = user;
    rq.rw   = rw;
    return rq;
  endfunction

  // mostly map/translate/unmap over a few directories, some noise
  function automatic walk_request_t random_request();
    walk_request_t rq;
    walk_request_t prior;
    int unsigned   pick;
    pick    = $urandom_range(0, 99);
    rq.op   = OP_MAP;
    rq.lin  = $urandom;
    rq.dir  = $urandom;
    rq.phys = $urandom;
    rq.user = 1'($urandom_range(0, 1));
    rq.rw   = 1'($urandom_range(0, 1));
    if (pick < 88) begin
      rq.dir[31:12] = dir_choices[$urandom_range(0, 3)];
      rq.lin[31:22] = pde_choices[$urandom_range(0, 3)];
    end
    if (pick < 35) begin
      recent_maps.push_back(rq);
      if (recent_maps.size() > 16) begin
        void'(recent_maps.pop_front());
      end
    end else if (pick < 75) begin
      if (recent_maps.size() != 0) begin
        prior = recent_maps[$urandom_range(0, recent_maps.size() - 1)];
        rq.dir        = prior.dir;
        rq.lin[31:12] = prior.lin[31:12];
      end
      rq.op = (pick < 58) ? OP_TRANSLATE : OP_UNMAP;
    end else if (pick < 88) begin
      rq.op = (pick < 82) ? OP_TRANSLATE : OP_UNMAP;
    end else if (pick < 96) begin
      rq.op = 2'($urandom_range(0, 3));
    end else begin
      rq.op = OP_UNUSED;
    end
    return rq;
  endfunction

  function automatic void find_absent_entry(output logic [19:0] dirf, output logic [9:0] pde);
    logic [31:0] word;
    dirf = '0;
    pde  = '0;
    for (int f = 0; f < STORE_FRAMES; f++) begin
      for (int i = 0; i < WORDS_PER_FRAME; i++) begin
        word = read_word(word_addr(f, i));
        if (!word[0]) begin
          dirf = 20'(f);
          pde  = 10'(i);
          return;
        end
      end
    end
  endfunction

  task automatic send_request(input walk_request_t rq);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= rq.op;
    in_linear_address   <= rq.lin;
    in_directory_base   <= rq.dir;
    in_physical_address <= rq.phys;
    in_user_access      <= rq.user;
    in_writable         <= rq.rw;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    due_results.push_back(walk_tables(rq));
  endtask

  task automatic write_free_base(input logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    table_pool_base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_map_and_translate();
    write_free_base(FREE_BASE_RESET);
    // directory low bits are ignored
    send_request(make_request(OP_MAP, 32'hFFFF_FFFF, 32'h0000_1FFF, 32'hFFFF_F123, 1'b1, 1'b1));
    send_request(make_request(OP_TRANSLATE, 32'hFFFF_F000, 32'h0000_1000, 32'h0, 1'b0, 1'b0));
    send_request(make_request(OP_MAP, 32'hFFC0_0000, 32'h0000_1000, 32'h0000_0FFF, 1'b0, 1'b0));
    send_request(make_request(OP_TRANSLATE, 32'hFFC0_0FFF, 32'h0000_1000, 32'hFFFF_FFFF,
                              1'b1, 1'b1));
    send_request(make_request(OP_MAP, 32'h0000_0000, 32'h0000_1000, 32'h1234_5000, 1'b0, 1'b1));
  endtask

  task automatic test_unmap();
    send_request(make_request(OP_UNMAP, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0, 1'b0, 1'b0));
    send_request(make_request(OP_UNMAP, 32'hFFFF_F000, 32'h0000_1000, 32'h0, 1'b1, 1'b1));
    send_request(make_request(OP_TRANSLATE, 32'hFFFF_F000, 32'h0000_1000, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_absent_directory_entry();
    send_request(make_request(OP_TRANSLATE, 32'h1234_5678, 32'h0000_5000, 32'h0, 1'b0, 1'b0));
    send_request(make_request(OP_UNMAP, 32'h1234_5678, 32'h0000_5000, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_store_range();
    send_request(make_request(OP_MAP, 32'h0000_1000, 32'h0020_0000, 32'h0000_1000, 1'b1, 1'b0));
    send_request(make_request(OP_TRANSLATE, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0));
    // last frame inside the store
    send_request(make_request(OP_MAP, 32'h0000_3000, 32'h001F_FFFF, 32'h0000_7000, 1'b0, 1'b1));
  endtask

  task automatic test_table_outside_store();
    logic [31:0] link;
    logic [31:0] alias_dir;
    send_request(make_request(OP_MAP, 32'h0040_2000, 32'h0000_3000, 32'hFFFF_F000, 1'b0, 1'b1));
    // reuse the new table as a directory: its entry 2 points far outside the store
    link      = read_word(word_addr(3, 1));
    alias_dir = {link[31:12], 12'h000};
    send_request(make_request(OP_TRANSLATE, 32'h0080_0000, alias_dir, 32'h0, 1'b0, 1'b0));
    send_request(make_request(OP_MAP, 32'h0080_0000, alias_dir, 32'h0000_2000, 1'b1, 1'b1));
    send_request(make_request(OP_UNMAP, 32'h0080_0000, alias_dir, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_allocator_extremes();
    // next table lands past the store
    write_free_base(32'h001F_F000);
    send_request(make_request(OP_MAP, 32'h0140_0000, 32'h0000_4000, 32'h0000_9000, 1'b1, 1'b0));
    // bump pointer wraps around to low frames
    write_free_base(32'hFFFF_FFFF);
    send_request(make_request(OP_MAP, 32'h0140_0000, 32'h0000_4000, 32'h0000_9000, 1'b1, 1'b0));
  endtask

  task automatic test_unused_operation();
    send_request(make_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              1'b1, 1'b1));
    send_request(make_request(OP_UNUSED, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_random_walks(input int idle_pct, input int stall_pct,
                                   input logic [31:0] base);
    write_free_base(base);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    recent_maps.delete();
    for (int k = 0; k < 4; k++) begin
      dir_choices[k] = 20'($urandom_range(0, STORE_FRAMES - 1));
      pde_choices[k] = 10'($urandom_range(0, WORDS_PER_FRAME - 1));
    end
    repeat (RANDOM_ITEMS) begin
      send_request(random_request());
    end
  endtask

  task automatic test_pool_exhaustion();
    logic [19:0] dirf;
    logic [9:0]  pde;
    logic [31:0] lin;
    write_free_base(FREE_BASE_RESET);
    while (tables_taken < POOL_PAGES) begin
      find_absent_entry(dirf, pde);
      lin        = $urandom;
      lin[31:22] = pde;
      send_request(make_request(OP_MAP, lin, {dirf, 12'h000}, $urandom,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
    // an existing table still takes entries once the pool is empty
    lin[21:12] = lin[21:12] + 1'b1;
    send_request(make_request(OP_MAP, lin, {dirf, 12'h000}, 32'hABCD_E000, 1'b1, 1'b1));
    send_request(make_request(OP_TRANSLATE, lin, {dirf, 12'h000}, 32'h0, 1'b0, 1'b0));
    find_absent_entry(dirf, pde);
    lin        = $urandom;
    lin[31:22] = pde;
    send_request(make_request(OP_MAP, lin, {dirf, 12'h000}, 32'h0000_5000, 1'b0, 1'b1));
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due: frame_base %h entry_present %b status %0d",
                 $time, out_frame_base, out_entry_present, out_status);
        error_count++;
      end else begin
        oldest_due = due_results.pop_front();
        if (out_frame_base !== oldest_due.frame_base) begin
          $display("%0t: frame_base expected %h actual %h", $time, oldest_due.frame_base,
                   out_frame_base);
          error_count++;
        end
        if (out_entry_present !== oldest_due.present) begin
          $display("%0t: entry_present expected %b actual %b", $time, oldest_due.present,
                   out_entry_present);
          error_count++;
        end
        if (out_status !== oldest_due.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest_due.status, out_status);
          error_count++;
        end
      end
    end
  end

  // the store clear after reset is the longest quiet stretch
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_operation        = OP_MAP;
    in_linear_address   = '0;
    in_directory_base   = '0;
    in_physical_address = '0;
    in_user_access      = 1'b0;
    in_writable         = 1'b0;
    cfg_valid           = 1'b0;
    cfg_data            = '0;
    page_words.delete();
    tables_taken        = '0;
    table_pool_base     = FREE_BASE_RESET;
    sender_idle_pct     = 9;
    receiver_stall_pct  = 77;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_map_and_translate();
    test_unmap();
    test_absent_directory_entry();
    test_store_range();
    test_table_outside_store();
    test_allocator_extremes();
    test_unused_operation();
    test_random_walks(9, 77, {20'($urandom_range(0, STORE_FRAMES - 1)),
                              12'($urandom_range(0, 4095))});
    test_random_walks(77, 9, 32'h0000_0000);
    test_random_walks(0, 0, 32'hFFFF_F000);
    test_pool_exhaustion();

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
